/* sv/dctfi_pkg.sv */
// ============================================================================
// dctfi_pkg - shared types and constants of the DCT forward/inverse block
// Command and status structs, register indexes and the cosine ROM builder.
// ============================================================================
package dctfi_pkg;

    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int ROM_Q   = 64;
    localparam int VAL_W   = 30;
    localparam int OUT_FRAC = 8;
    localparam int LOG2_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG2_LENGTH  = 2'd1;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic              issue;
        logic              clr;
        logic [IDX_W-1:0]  i;
        logic [IDX_W-1:0]  k;
        logic              inv;
        logic [LOG2_W-1:0] l;
        logic              load_out;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

    // shift-subtract quotient, evaluated only while the ROM is elaborated
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // quarter-wave cosine magnitude, entry j = cos(j*pi/128) rounded to frac bits
    function automatic logic [31:0] cos_rom_entry(input int unsigned j,
                                                  input int unsigned frac);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned dv;
        longint          sum;
        longint unsigned res;
        x    = (longint'(j) * PI_Q30 + 64'd64) >> 7;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (int n = 1; n <= 12; n++) begin
            dv   = longint'((2 * n - 1) * (2 * n));
            term = udiv64((term * x2) >> 30, dv);
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
        end
        res = (longint'(sum) + (longint'(1) << (29 - frac))) >> (30 - frac);
        return 32'(res);
    endfunction

endpackage

/* sv/dctfi_ctrl.sv */
// ============================================================================
// dctfi_ctrl - sequencer of the DCT block
// Holds configuration and the load count, steps the MAC over i and k.
// ============================================================================
module dctfi_ctrl #(
    parameter int MAX_LEN = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dctfi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dctfi_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  dctfi_pkg::t_stat                    i_stat,
    output dctfi_pkg::t_cmd                     o_cmd
);

    localparam int LMAX = $clog2(MAX_LEN + 1) - 1;
    localparam logic [dctfi_pkg::LOG2_W-1:0] LMAX_L = dctfi_pkg::LOG2_W'(LMAX);

    typedef enum logic [1:0] {S_LOAD, S_RUN, S_DRAIN, S_DONE} t_state;

    t_state                            r_state;
    logic                              r_inv;
    logic [dctfi_pkg::LOG2_W-1:0]      r_log2;
    logic [dctfi_pkg::CNT_W-1:0]       r_cnt;
    logic [dctfi_pkg::IDX_W-1:0]       r_i;
    logic [dctfi_pkg::IDX_W-1:0]       r_k;
    logic                              r_drain;

    logic [dctfi_pkg::LOG2_W-1:0]      w_l;
    logic [dctfi_pkg::CNT_W-1:0]       w_n;
    logic [dctfi_pkg::IDX_W-1:0]       w_nm1;
    logic [dctfi_pkg::CNT_W-1:0]       n_cnt;

    assign w_l   = (r_log2 > LMAX_L) ? LMAX_L : r_log2;
    assign w_n   = dctfi_pkg::CNT_W'(1) << w_l;
    assign w_nm1 = dctfi_pkg::IDX_W'(w_n - dctfi_pkg::CNT_W'(1));
    assign n_cnt = r_cnt + dctfi_pkg::CNT_W'(1);

    assign o_s_tready = (r_state == S_LOAD);

    always_comb begin
        o_cmd          = '0;
        o_cmd.wr_en    = (r_state == S_LOAD) && i_s_tvalid;
        o_cmd.wr_addr  = r_cnt[dctfi_pkg::IDX_W-1:0];
        o_cmd.issue    = (r_state == S_RUN);
        o_cmd.clr      = (r_i == '0);
        o_cmd.i        = r_i;
        o_cmd.k        = r_k;
        o_cmd.inv      = r_inv;
        o_cmd.l        = w_l;
        o_cmd.load_out = (r_state == S_DONE) && !i_stat.out_busy;
        o_cmd.last     = (r_k == w_nm1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_inv   <= 1'b0;
            r_log2  <= 3'd6;
            r_cnt   <= '0;
            r_i     <= '0;
            r_k     <= '0;
            r_drain <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (i_s_tvalid) begin
                        if (n_cnt == w_n) begin
                            r_cnt   <= '0;
                            r_i     <= '0;
                            r_k     <= '0;
                            r_state <= S_RUN;
                        end else begin
                            r_cnt <= n_cnt;
                        end
                    end
                end
                S_RUN: begin
                    if (r_i == w_nm1) begin
                        r_drain <= 1'b1;
                        r_state <= S_DRAIN;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (r_drain) begin
                        r_drain <= 1'b0;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!i_stat.out_busy) begin
                        r_i <= '0;
                        if (r_k == w_nm1) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_RUN;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
            if (i_cfg_we) begin
                if (i_cfg_idx == dctfi_pkg::REG_INVERSE_MODE) begin
                    r_inv <= i_cfg_data[0];
                end else if (i_cfg_idx == dctfi_pkg::REG_LOG2_LENGTH) begin
                    r_log2 <= i_cfg_data;
                    r_cnt  <= '0;
                end
            end
        end
    end

endmodule

/* sv/dctfi_dp.sv */
// ============================================================================
// dctfi_dp - datapath of the DCT block
// Sample store, cosine ROM, one MAC pipeline, scaling, saturation, output reg.
// ============================================================================
module dctfi_dp #(
    parameter int MAX_LEN       = 64,
    parameter int SAMPLE_BITS   = 16,
    parameter int COS_FRAC_BITS = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dctfi_pkg::t_cmd                     i_cmd,
    input  logic [SAMPLE_BITS-1:0]              i_sample,
    input  logic                                i_m_tready,
    output dctfi_pkg::t_stat                    o_stat,
    output logic                                o_valid,
    output logic [dctfi_pkg::VAL_W-1:0]         o_value,
    output logic [dctfi_pkg::IDX_W-1:0]         o_index,
    output logic                                o_last
);

    localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int MW     = COS_FRAC_BITS + 1;
    localparam int CW     = COS_FRAC_BITS + 2;
    localparam int PW     = SAMPLE_BITS + CW;
    localparam int ACC_W  = PW + 6;
    localparam int EW     = (ACC_W + 2 > dctfi_pkg::VAL_W + 1) ? ACC_W + 2
                                                              : dctfi_pkg::VAL_W + 1;
    localparam int BASE_SH = COS_FRAC_BITS - dctfi_pkg::OUT_FRAC;
    localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (dctfi_pkg::VAL_W - 1)) - 1);
    localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);
    localparam logic signed [CW-1:0] HALF_ONE = CW'(1) << (COS_FRAC_BITS - 1);

    logic signed [SAMPLE_BITS-1:0] r_mem [MAX_LEN];

    logic [MW-1:0]                 w_rom [dctfi_pkg::ROM_Q + 1];

    for (genvar j = 0; j <= dctfi_pkg::ROM_Q; j++) begin : g_rom
        localparam logic [MW-1:0] ROM_V = MW'(dctfi_pkg::cos_rom_entry(j, COS_FRAC_BITS));
        assign w_rom[j] = ROM_V;
    end

    // phase lookup
    logic [6:0]                    w_a;
    logic [5:0]                    w_b;
    logic [12:0]                   w_pp;
    logic [2:0]                    w_psh;
    logic [7:0]                    w_ph;
    logic [6:0]                    w_ridx;
    logic                          w_neg;
    logic signed [CW-1:0]          w_mag;
    logic signed [CW-1:0]          w_cos;

    assign w_a   = i_cmd.inv ? {i_cmd.k, 1'b1} : {i_cmd.i, 1'b1};
    assign w_b   = i_cmd.inv ? i_cmd.i : i_cmd.k;
    assign w_pp  = 13'(w_a) * 13'(w_b);
    assign w_psh = 3'd6 - i_cmd.l;
    assign w_ph  = w_pp[7:0] << w_psh;

    always_comb begin
        if (w_ph <= 8'd64) begin
            w_ridx = w_ph[6:0];
            w_neg  = 1'b0;
        end else if (w_ph <= 8'd128) begin
            w_ridx = 7'(9'd128 - {1'b0, w_ph});
            w_neg  = 1'b1;
        end else if (w_ph <= 8'd192) begin
            w_ridx = 7'({1'b0, w_ph} - 9'd128);
            w_neg  = 1'b1;
        end else begin
            w_ridx = 7'(9'd256 - {1'b0, w_ph});
            w_neg  = 1'b0;
        end
    end

    assign w_mag = $signed(CW'(w_rom[w_ridx]));

    always_comb begin
        if (i_cmd.inv && (i_cmd.i == '0)) begin
            w_cos = HALF_ONE;
        end else if (w_neg) begin
            w_cos = -w_mag;
        end else begin
            w_cos = w_mag;
        end
    end

    // MAC pipeline
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic signed [CW-1:0]          r_cos;
    logic                          r_v1;
    logic                          r_c1;
    logic signed [PW-1:0]          r_prod;
    logic                          r_v2;
    logic                          r_c2;
    logic signed [ACC_W-1:0]       r_acc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr[AW-1:0]] <= $signed(i_sample);
        end
        if (i_cmd.issue) begin
            r_smp <= r_mem[i_cmd.i[AW-1:0]];
            r_cos <= w_cos;
        end
        r_prod <= r_smp * r_cos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_c1  <= 1'b0;
            r_v2  <= 1'b0;
            r_c2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_c1 <= i_cmd.clr;
            r_v2 <= r_v1;
            r_c2 <= r_c1;
            if (r_v2) begin
                r_acc <= r_c2 ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
            end
        end
    end

    // scale, round half up, saturate
    logic signed [5:0]             w_sh;
    logic [4:0]                    w_shu;
    logic signed [EW-1:0]          w_ext;
    logic signed [EW-1:0]          w_rnd;
    logic signed [EW-1:0]          w_scl;
    logic [dctfi_pkg::VAL_W-1:0]   w_val;

    assign w_sh  = i_cmd.inv ? 6'(BASE_SH) + 6'(i_cmd.l) - 6'sd1 : 6'(BASE_SH);
    assign w_shu = w_sh[4:0];
    assign w_ext = EW'(r_acc);
    assign w_rnd = w_ext + (EW'(1) << (w_shu - 5'd1));

    always_comb begin
        if (w_sh > 6'sd0) begin
            w_scl = w_rnd >>> w_shu;
        end else if (w_sh < 6'sd0) begin
            w_scl = w_ext <<< 1;
        end else begin
            w_scl = w_ext;
        end
        if (w_scl > SAT_HI) begin
            w_val = dctfi_pkg::VAL_W'(SAT_HI);
        end else if (w_scl < SAT_LO) begin
            w_val = dctfi_pkg::VAL_W'(SAT_LO);
        end else begin
            w_val = w_scl[dctfi_pkg::VAL_W-1:0];
        end
    end

    // output register
    logic                          r_out_valid;
    logic [dctfi_pkg::VAL_W-1:0]   r_out_value;
    logic [dctfi_pkg::IDX_W-1:0]   r_out_index;
    logic                          r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_value <= w_val;
            r_out_index <= i_cmd.k;
            r_out_last  <= i_cmd.last;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_m_tready;
    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_index = r_out_index;
    assign o_last  = r_out_last;

endmodule

/* sv/dct_forward_inverse.sv */
// ============================================================================
// dct_forward_inverse - direct-form DCT-II and inverse DCT block
// Loads N samples, then streams N transform results in index order.
// ============================================================================
// Samples are taken one per cycle while i_s_tvalid is high until N =
// 2^log2_length (at most MAX_LEN) have arrived; the block then computes the N
// results with a single multiply-accumulate unit fed by the sample store read
// port and a quarter-wave cosine ROM. Each result runs the MAC over all N
// samples, then drains the pipeline and loads the output register. No sample
// is taken while results are being computed. Results leave through the output
// register, so computing the next result overlaps a stalled one.
// ============================================================================
module dct_forward_inverse #(
    parameter int MAX_LEN       = 64,
    parameter int SAMPLE_BITS   = 16,
    parameter int COS_FRAC_BITS = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dctfi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dctfi_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [15:0]                         i_s_tdata,   // sample[15:0]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [39:0]                         o_m_tdata,   // value[29:0], index[35:30]
    output logic                                o_m_tlast
);

    dctfi_pkg::t_cmd                w_cmd;
    dctfi_pkg::t_stat               w_stat;
    logic [SAMPLE_BITS-1:0]         w_sample;
    logic [dctfi_pkg::VAL_W-1:0]    w_value;
    logic [dctfi_pkg::IDX_W-1:0]    w_index;

    assign w_sample = SAMPLE_BITS'(i_s_tdata);

    dctfi_ctrl #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    dctfi_dp #(
        .MAX_LEN       (MAX_LEN),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .COS_FRAC_BITS (COS_FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_sample   (w_sample),
        .i_m_tready (i_m_tready),
        .o_stat     (w_stat),
        .o_valid    (o_m_tvalid),
        .o_value    (w_value),
        .o_index    (w_index),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {4'b0000, w_index, w_value};

    a_no_load_while_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue |-> !o_s_tready)
        else $error("sample port open during MAC run");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !(o_m_tvalid && !i_m_tready))
        else $error("result overwritten while stalled");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_m_tvalid && (w_index == $past(w_cmd.k)))
        else $error("loaded result not presented");

endmodule
